@@ src/pfa_pkg.sv @@
// Shared types, constants and codes of the page-frame allocator.
package pfa_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_PAGES_DEF = 1024;
  localparam int REF_BITS_DEF  = 16;

  // Fixed field widths of the stream and configuration ports.
  localparam int CMD_W       = 2;
  localparam int PAGE_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int RC_W        = 16;
  localparam int CNT_W       = 11;
  localparam int TAG_W       = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CNT_W-1:0]  PAGE_COUNT_RST = 11'd1024;
  localparam logic [PAGE_W-1:0] FIRST_FREE_RST = 10'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_DUP   = 2'd2,
    CMD_PUT   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_BAD_FREE  = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_LOOP      = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [TAG_W-1:0] {
    TAG_RESERVED  = 2'd0,
    TAG_FREE_NEXT = 2'd1,
    TAG_FREE_LAST = 2'd2,
    TAG_ALLOCATED = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_SWEEP = 2'd2,
    FSM_EXEC  = 2'd3
  } fsm_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic ready;       // input beat may be taken
    logic accept;      // input beat taken this cycle
    logic sweep;       // write one page of the sweep this cycle
    logic sweep_link;  // sweep builds the free list (init) instead of clearing
    logic exec_go;     // finish the command and load the result register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sweep_last;  // sweep is at its final page
    logic slot_free;   // result register can take a new beat
  } dp_sts_t;

endpackage

@@ src/pfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ src/pfa_ctrl.sv @@
// Command sequencer of the page-frame allocator.
module pfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  pfa_pkg::cmd_t       in_cmd,
  input  pfa_pkg::dp_sts_t    sts,
  output pfa_pkg::ctrl_cmd_t  cmd
);

  pfa_pkg::fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      pfa_pkg::FSM_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = pfa_pkg::FSM_IDLE;
        end
      end
      pfa_pkg::FSM_IDLE: begin
        cmd.ready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == pfa_pkg::CMD_INIT) ? pfa_pkg::FSM_SWEEP
                                                    : pfa_pkg::FSM_EXEC;
        end
      end
      pfa_pkg::FSM_SWEEP: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_link = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = pfa_pkg::FSM_EXEC;
        end
      end
      pfa_pkg::FSM_EXEC: begin
        if (sts.slot_free) begin
          cmd.exec_go = 1'b1;
          state_nxt   = pfa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = pfa_pkg::FSM_CLEAR;
      end
    endcase
  end

endmodule

@@ src/pfa_dp.sv @@
// Datapath of the page-frame allocator: page memories, free-list head and result register.
module pfa_dp #(
  parameter int MAX_PAGES = pfa_pkg::MAX_PAGES_DEF,
  parameter int REF_BITS  = pfa_pkg::REF_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfa_pkg::ctrl_cmd_t                  cmd,
  output pfa_pkg::dp_sts_t                    sts,
  input  pfa_pkg::cmd_t                       in_cmd,
  input  logic [pfa_pkg::PAGE_W-1:0]          in_page,
  input  logic                                cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfa_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int EW = (CW > pfa_pkg::CNT_W) ? CW : pfa_pkg::CNT_W;
  localparam int LW = pfa_pkg::TAG_W + AW;
  localparam int PAD_W = pfa_pkg::OUT_DATA_W - pfa_pkg::STATUS_W - pfa_pkg::PAGE_W
                         - pfa_pkg::RC_W;

  // Configuration registers.
  logic [pfa_pkg::CNT_W-1:0]  page_count_r;
  logic [pfa_pkg::PAGE_W-1:0] first_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= pfa_pkg::PAGE_COUNT_RST;
      first_free_r <= pfa_pkg::FIRST_FREE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pfa_pkg::REG_PAGE_COUNT: page_count_r <= cfg_wdata;
        pfa_pkg::REG_FIRST_FREE: first_free_r <= cfg_wdata[pfa_pkg::PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched command and page of the beat in progress.
  pfa_pkg::cmd_t              cmd_r;
  logic [pfa_pkg::PAGE_W-1:0] page_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_cmd;
      page_r <= in_page;
    end
  end

  // Sweep counter for the clearing pass and for init.
  logic [AW-1:0] cnt_r;
  logic          sweep_last;

  assign sweep_last = (cnt_r == AW'(MAX_PAGES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sweep) begin
      cnt_r <= sweep_last ? '0 : cnt_r + AW'(1);
    end
  end

  // Free-list head.
  logic [AW-1:0] head_r, head_nxt;
  logic          nonempty_r, nonempty_nxt;

  // Memories.
  logic                link_we, refs_we, mem_re;
  logic [AW-1:0]       link_wa, refs_wa, mem_ra;
  logic [LW-1:0]       link_wd, link_rd;
  logic [REF_BITS-1:0] refs_wd, refs_rd;

  assign mem_re = cmd.accept;
  assign mem_ra = (in_cmd == pfa_pkg::CMD_ALLOC) ? head_r : AW'(in_page);

  pfa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES)) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .waddr   (link_wa),
    .wdata   (link_wd),
    .re      (mem_re),
    .raddr   (mem_ra),
    .rdata_r (link_rd)
  );

  pfa_ram #(.WIDTH(REF_BITS), .DEPTH(MAX_PAGES)) u_refs_ram (
    .clk     (clk),
    .we      (refs_we),
    .waddr   (refs_wa),
    .wdata   (refs_wd),
    .re      (mem_re),
    .raddr   (mem_ra),
    .rdata_r (refs_rd)
  );

  // Sweep entry contents.
  logic [EW-1:0] cnt_e, cnt_inc_e, count_e, max_e, first_e;
  logic          in_list, is_last;
  logic [LW-1:0] sweep_link;

  assign cnt_e     = EW'(cnt_r);
  assign cnt_inc_e = cnt_e + EW'(1);
  assign count_e   = EW'(page_count_r);
  assign max_e     = EW'(MAX_PAGES);
  assign first_e   = EW'(first_free_r);
  assign in_list   = cmd.sweep_link && (cnt_e >= first_e) && (cnt_e < count_e);
  assign is_last   = (cnt_inc_e >= count_e) || (cnt_inc_e >= max_e);

  always_comb begin
    if (!in_list) begin
      sweep_link = {pfa_pkg::TAG_RESERVED, AW'(0)};
    end else if (is_last) begin
      sweep_link = {pfa_pkg::TAG_FREE_LAST, AW'(0)};
    end else begin
      sweep_link = {pfa_pkg::TAG_FREE_NEXT, cnt_r + AW'(1)};
    end
  end

  // Command evaluation on the read data.
  pfa_pkg::tag_t       rd_tag;
  logic [AW-1:0]       rd_next, page_a;
  logic                bad_index, next_bad;
  logic [REF_BITS-1:0] ref_max;

  assign rd_tag    = pfa_pkg::tag_t'(link_rd[LW-1 -: pfa_pkg::TAG_W]);
  assign rd_next   = link_rd[AW-1:0];
  assign page_a    = AW'(page_r);
  assign bad_index = (EW'(page_r) >= count_e) || (EW'(page_r) >= max_e);
  assign next_bad  = (rd_next == head_r) || ({1'b0, rd_next} >= (AW + 1)'(MAX_PAGES));
  assign ref_max   = {REF_BITS{1'b1}};

  pfa_pkg::status_t           res_status;
  logic [pfa_pkg::PAGE_W-1:0] res_page;
  logic [REF_BITS-1:0]        res_rc;
  logic                       x_link_we, x_refs_we;
  logic [AW-1:0]              x_addr;
  logic [LW-1:0]              x_link_wd;
  logic [REF_BITS-1:0]        x_refs_wd;

  always_comb begin
    res_status   = pfa_pkg::ST_OK;
    res_page     = page_r;
    res_rc       = '0;
    x_link_we    = 1'b0;
    x_refs_we    = 1'b0;
    x_addr       = page_a;
    x_link_wd    = {pfa_pkg::TAG_ALLOCATED, AW'(0)};
    x_refs_wd    = '0;
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    case (cmd_r)
      pfa_pkg::CMD_INIT: begin
        head_nxt     = AW'(first_free_r);
        nonempty_nxt = (first_e < count_e) && (first_e < max_e);
      end
      pfa_pkg::CMD_ALLOC: begin
        res_page = '0;
        if (!nonempty_r) begin
          res_status = pfa_pkg::ST_OOM;
        end else begin
          res_page = pfa_pkg::PAGE_W'(head_r);
          if ((rd_tag == pfa_pkg::TAG_FREE_NEXT && next_bad) ||
              (rd_tag != pfa_pkg::TAG_FREE_NEXT && rd_tag != pfa_pkg::TAG_FREE_LAST)) begin
            res_status = pfa_pkg::ST_LOOP;
          end else begin
            x_addr    = head_r;
            x_link_we = 1'b1;
            x_refs_we = 1'b1;
            x_refs_wd = REF_BITS'(1);
            res_rc    = REF_BITS'(1);
            if (rd_tag == pfa_pkg::TAG_FREE_NEXT) begin
              head_nxt = rd_next;
            end else begin
              nonempty_nxt = 1'b0;
            end
          end
        end
      end
      pfa_pkg::CMD_DUP: begin
        if (bad_index) begin
          res_status = pfa_pkg::ST_BAD_INDEX;
        end else if (refs_rd == ref_max) begin
          res_status = pfa_pkg::ST_OVERFLOW;
          res_rc     = refs_rd;
        end else begin
          x_refs_we = 1'b1;
          x_refs_wd = refs_rd + REF_BITS'(1);
          res_rc    = refs_rd + REF_BITS'(1);
        end
      end
      pfa_pkg::CMD_PUT: begin
        if (bad_index) begin
          res_status = pfa_pkg::ST_BAD_INDEX;
        end else if (refs_rd == '0) begin
          res_status = pfa_pkg::ST_BAD_FREE;
        end else if (refs_rd != REF_BITS'(1)) begin
          x_refs_we = 1'b1;
          x_refs_wd = refs_rd - REF_BITS'(1);
          res_rc    = refs_rd - REF_BITS'(1);
        end else if (rd_tag != pfa_pkg::TAG_ALLOCATED) begin
          res_status = pfa_pkg::ST_BAD_FREE;
          res_rc     = refs_rd;
        end else begin
          // Last reference dropped: push the page on top of the free list.
          x_link_we    = 1'b1;
          x_refs_we    = 1'b1;
          x_link_wd    = nonempty_r ? {pfa_pkg::TAG_FREE_NEXT, head_r}
                                    : {pfa_pkg::TAG_FREE_LAST, AW'(0)};
          head_nxt     = page_a;
          nonempty_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Write port muxing between the sweep and command completion.
  assign link_we = cmd.sweep | (cmd.exec_go & x_link_we);
  assign refs_we = cmd.sweep | (cmd.exec_go & x_refs_we);
  assign link_wa = cmd.sweep ? cnt_r : x_addr;
  assign refs_wa = cmd.sweep ? cnt_r : x_addr;
  assign link_wd = cmd.sweep ? sweep_link : x_link_wd;
  assign refs_wd = cmd.sweep ? '0 : x_refs_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      nonempty_r <= 1'b0;
    end else if (cmd.exec_go) begin
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

  // Result register.
  logic                       out_valid_r;
  pfa_pkg::status_t           out_status_r;
  logic [pfa_pkg::PAGE_W-1:0] out_page_r;
  logic [pfa_pkg::RC_W-1:0]   out_rc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_go) begin
      out_status_r <= res_status;
      out_page_r   <= res_page;
      out_rc_r     <= pfa_pkg::RC_W'(res_rc);
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {PAD_W'(0), out_rc_r, out_page_r, out_status_r};
  assign sts.sweep_last = sweep_last;
  assign sts.slot_free  = !out_valid_r || out_tready;

endmodule

@@ src/page_frame_allocator_refcount_core.sv @@
// Top level of the page-frame allocator with per-page reference counts.
//
// This block hands out physical page frames from a LIFO free list that is
// threaded through a per-page link memory, and keeps a reference count for
// every page in a second memory. A command beat on the in_ stream is one of
// init, allocate, duplicate or release, and every command beat produces
// exactly one result beat on the out_ stream carrying a status code, a page
// number and the page's reference count after the operation. Errors (empty
// list, corrupt or self-linked head, bad free, index at or beyond the page
// count, count saturation) are reported in the status field and leave all
// state untouched. For allocate, duplicate and release the beat is accepted
// and both memories are read in the idle state, and the decision plus the
// write-back happen in the exec state once the result register can take a
// beat; each memory has a single read and a single write port. Init walks
// every entry of both memories, one page per cycle, before its exec state.
// After reset the block runs a clearing pass that marks every page reserved
// with a zero count; in_tready stays low during that pass. The input side
// is ready again as soon as a command has finished, even while its result
// beat still waits in the output register. Configuration writes are only
// allowed while no command is in flight; page_count values above MAX_PAGES
// are clamped to MAX_PAGES.
module page_frame_allocator_refcount_core #(
  parameter int MAX_PAGES = pfa_pkg::MAX_PAGES_DEF,
  parameter int REF_BITS  = pfa_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pfa_pkg::IN_DATA_W-1:0]   in_tdata,   // cmd[1:0], page_index[11:2], zero pad
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pfa_pkg::OUT_DATA_W-1:0]  out_tdata,  // status[2:0], result_page[12:3],
                                                      // ref_count[28:13], zero pad
  // Configuration write port: index 0 page_count, index 1 first_free_page.
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pfa_pkg::ctrl_cmd_t         ctrl_cmd;
  pfa_pkg::dp_sts_t           dp_sts;
  pfa_pkg::cmd_t              in_cmd;
  logic [pfa_pkg::PAGE_W-1:0] in_page;

  // Unpack the command beat.
  assign in_cmd  = pfa_pkg::cmd_t'(in_tdata[pfa_pkg::CMD_W-1:0]);
  assign in_page = in_tdata[pfa_pkg::CMD_W +: pfa_pkg::PAGE_W];

  // The sequencer only ever takes a beat from its idle state.
  assign in_tready = ctrl_cmd.ready;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_cmd),
    .sts       (dp_sts),
    .cmd       (ctrl_cmd)
  );

  pfa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .REF_BITS  (REF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctrl_cmd),
    .sts        (dp_sts),
    .in_cmd     (in_cmd),
    .in_page    (in_page),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the page-frame allocator with per-page reference counts.
`timescale 1ns / 1ps

module tb;
  import pfa_pkg::*;

  localparam int NPAGES          = MAX_PAGES_DEF;
  localparam logic [RC_W-1:0] RC_MAX = '1;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int REPORT_LIMIT    = 10;

  // One result beat split into its fields.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [RC_W-1:0]     refs;
  } page_result_t;

  // Mirror of the allocator: the free list, the per-page counts and the two
  // registers. Every accepted command updates the mirror and queues the result
  // beat the core has to return for it.
  class page_alloc_scoreboard;
    tag_t              link_tag  [NPAGES];
    logic [PAGE_W-1:0] link_next [NPAGES];
    logic [RC_W-1:0]   refs      [NPAGES];
    logic [PAGE_W-1:0] head;
    bit                list_live;
    logic [CNT_W-1:0]  page_count_reg;
    logic [PAGE_W-1:0] first_free_reg;
    page_result_t      pending_results [$];
    int                mismatches;

    function new();
      wipe();
      page_count_reg = PAGE_COUNT_RST;
      first_free_reg = FIRST_FREE_RST;
      mismatches     = 0;
    endfunction

    function void wipe();
      foreach (link_tag[i]) begin
        link_tag[i]  = TAG_RESERVED;
        link_next[i] = '0;
        refs[i]      = '0;
      end
      head      = '0;
      list_live = 1'b0;
    endfunction

    function int eff_pages();
      return (page_count_reg < NPAGES) ? int'(page_count_reg) : NPAGES;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      if (addr == REG_PAGE_COUNT) begin
        page_count_reg = value;
      end else begin
        first_free_reg = value[PAGE_W-1:0];
      end
    endfunction

    // Init: everything reserved, then first_free .. count-1 chained upward.
    function void build_list();
      int n;
      n = eff_pages();
      wipe();
      if (int'(first_free_reg) >= n) return;
      for (int i = first_free_reg; i + 1 < n; i++) begin
        link_tag[i]  = TAG_FREE_NEXT;
        link_next[i] = PAGE_W'(i + 1);
      end
      link_tag[n-1]  = TAG_FREE_LAST;
      link_next[n-1] = '0;
      head           = first_free_reg;
      list_live      = 1'b1;
    endfunction

    function void note_command(cmd_t op, logic [PAGE_W-1:0] idx);
      page_result_t      r;
      logic [PAGE_W-1:0] h;
      r.status = ST_OK;
      r.page   = idx;
      r.refs   = '0;
      case (op)
        CMD_INIT: begin
          build_list();
        end
        CMD_ALLOC: begin
          r.page = '0;
          if (!list_live) begin
            r.status = ST_OOM;
          end else begin
            h      = head;
            r.page = h;
            if (link_tag[h] == TAG_FREE_NEXT && link_next[h] == h) begin
              r.status = ST_LOOP;
            end else if (link_tag[h] != TAG_FREE_NEXT && link_tag[h] != TAG_FREE_LAST) begin
              r.status = ST_LOOP;
            end else begin
              if (link_tag[h] == TAG_FREE_NEXT) head = link_next[h];
              else list_live = 1'b0;
              link_tag[h]  = TAG_ALLOCATED;
              link_next[h] = '0;
              refs[h]      = RC_W'(1);
              r.refs       = RC_W'(1);
            end
          end
        end
        default: begin
          if (int'(idx) >= eff_pages()) begin
            r.status = ST_BAD_INDEX;
          end else if (op == CMD_DUP) begin
            if (refs[idx] == RC_MAX) r.status = ST_OVERFLOW;
            else refs[idx] = refs[idx] + 1'b1;
            r.refs = refs[idx];
          end else begin
            if (refs[idx] == 0) begin
              r.status = ST_BAD_FREE;
            end else if (refs[idx] > 1) begin
              refs[idx] = refs[idx] - 1'b1;
            end else if (link_tag[idx] != TAG_ALLOCATED) begin
              r.status = ST_BAD_FREE;
            end else begin
              // Last reference gone: the page goes back on top of the list.
              link_tag[idx]  = list_live ? TAG_FREE_NEXT : TAG_FREE_LAST;
              link_next[idx] = list_live ? head : '0;
              head           = idx;
              list_live      = 1'b1;
              refs[idx]      = '0;
            end
            r.refs = refs[idx];
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] beat);
      page_result_t got, want;
      got.status = beat[2:0];
      got.page   = beat[12:3];
      got.refs   = beat[28:13];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: status %0d page %0d count %0d",
                   got.status, got.page, got.refs);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.page !== want.page || got.refs !== want.refs) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result mismatch: expected status %0d page %0d count %0d, ",
                    "got status %0d page %0d count %0d"},
                   want.status, want.page, want.refs, got.status, got.page, got.refs);
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // cmd[1:0], page_index[11:2], zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // status[2:0], result_page[12:3], ref_count[28:13]
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  page_alloc_scoreboard sb = new();

  // Idling control. Each side works in runs of beats: some runs have no
  // gaps at all, the others draw a fresh random wait for every beat.
  int tx_run = 0;
  bit tx_steady;

  always #2 clk = ~clk;

  page_frame_allocator_refcount_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Result side: every beat taken by the handshake is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side backpressure. out_tready is raised after the drawn stall and
  // held until a beat has been taken on it.
  initial begin : result_sink
    int rx_run;
    int stall;
    bit rx_steady;
    rx_run = 0;
    forever begin
      if (rx_run == 0) begin
        rx_run    = $urandom_range(60, 10);
        rx_steady = ($urandom_range(2, 0) == 0);
      end
      rx_run--;
      stall = rx_steady ? 0 : $urandom_range(19, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  // Run-away guard: the slowest legal run stays well below this count.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL page_frame_allocator_refcount_core");
    $finish;
  end

  // Presents one command beat and returns at the edge that takes it. tvalid
  // stays high when the next beat follows without a gap, so it is lowered only
  // ahead of a wait.
  task automatic send_cmd(cmd_t op, logic [PAGE_W-1:0] idx);
    int gap;
    if (tx_run == 0) begin
      tx_run    = $urandom_range(60, 10);
      tx_steady = ($urandom_range(2, 0) == 0);
    end
    tx_run--;
    gap = tx_steady ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W - CMD_W - PAGE_W){1'b0}}, idx, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_command(op, idx);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  // Since every command returns exactly one beat, the core is idle then.
  // The queue is polled on the falling edge so the check never races the
  // result monitor.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes page_count, then first_free; the core must be idle.
  task automatic configure(logic [CNT_W-1:0] pages, logic [PAGE_W-1:0] first_free);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PAGE_COUNT;
    cfg_wdata <= pages;
    @(posedge clk);
    sb.set_reg(REG_PAGE_COUNT, pages);
    cfg_addr  <= REG_FIRST_FREE;
    cfg_wdata <= {1'b0, first_free};
    @(posedge clk);
    sb.set_reg(REG_FIRST_FREE, {1'b0, first_free});
    cfg_we    <= 1'b0;
  endtask

  // Page choice for duplicate and release. Most picks try to land on a page
  // that holds references, so that releases actually free pages and the list
  // keeps cycling; the rest hit free and reserved pages, the first pages past
  // the count, and anywhere in the index range.
  function automatic logic [PAGE_W-1:0] pick_page();
    int n;
    int lo;
    int roll;
    int cand;
    n    = sb.eff_pages();
    lo   = sb.first_free_reg;
    roll = $urandom_range(99, 0);
    if (roll < 55 && lo < n) begin
      cand = $urandom_range(n - 1, lo);
      for (int t = 0; t < 8 && sb.refs[cand] == 0; t++) cand = $urandom_range(n - 1, lo);
      return PAGE_W'(cand);
    end
    if (roll < 75 && n > 0) return PAGE_W'($urandom_range(n - 1, 0));
    if (roll < 88) return PAGE_W'($urandom_range((n + 1 > NPAGES - 1) ? NPAGES - 1 : n + 1, 0));
    return PAGE_W'($urandom_range(NPAGES - 1, 0));
  endfunction

  initial begin : stimulus
    int phase_pages [10] = '{1024, 1, 0, 2047, 8, 16, 6, 1024, 3, 24};
    int phase_first [10] = '{0,    0, 0, 1023, 3, 0,  6, 1023, 2, 20};
    int pages;
    int first_free;
    int roll;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // The core clears its memories after reset and holds in_tready low
    // meanwhile; configuration waits for that pass to end.
    do @(posedge clk); while (!in_tready);

    // Directed part on a four-page setup with page 0 reserved: exhaust the
    // list, duplicate, release down to zero, double free, indexes past the count,
    // release of a reserved page, then reuse of freed pages.
    configure(11'd4, 10'd1);
    send_cmd(CMD_INIT,  10'h3FF);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_ALLOC, 10'h3FF);
    send_cmd(CMD_ALLOC, 10'h155);
    send_cmd(CMD_ALLOC, 10'h2AA);   // list is empty now
    send_cmd(CMD_DUP,   10'd3);
    send_cmd(CMD_PUT,   10'd3);
    send_cmd(CMD_PUT,   10'd3);     // last reference: page 3 goes back
    send_cmd(CMD_PUT,   10'd3);     // double free
    send_cmd(CMD_PUT,   10'd4);     // first index past the count
    send_cmd(CMD_DUP,   10'h3FF);   // far past the count
    send_cmd(CMD_DUP,   10'd0);     // reserved page gains a reference
    send_cmd(CMD_PUT,   10'd0);     // and cannot be freed through it
    send_cmd(CMD_DUP,   10'd3);     // free page gains a reference
    send_cmd(CMD_ALLOC, 10'h000);   // allocation resets its count to one
    send_cmd(CMD_PUT,   10'd2);
    send_cmd(CMD_PUT,   10'd1);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_INIT,  10'h000);
    send_cmd(CMD_ALLOC, 10'h000);

    // Random part: fixed corner setups first, then small random ones where
    // the list runs dry often. Each phase starts from a fresh init.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 10) begin
        pages      = phase_pages[p];
        first_free = phase_first[p];
      end else begin
        pages      = $urandom_range(40, 1);
        first_free = $urandom_range(pages, 0);
      end
      drain();
      configure(CNT_W'(pages), PAGE_W'(first_free));
      send_cmd(CMD_INIT, PAGE_W'($urandom_range(NPAGES - 1, 0)));
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(99, 0);
        if (roll < 3) send_cmd(CMD_INIT, PAGE_W'($urandom_range(NPAGES - 1, 0)));
        else if (roll < 40) send_cmd(CMD_ALLOC, PAGE_W'($urandom_range(NPAGES - 1, 0)));
        else if (roll < 58) send_cmd(CMD_DUP, pick_page());
        else send_cmd(CMD_PUT, pick_page());
        // Now and then the sender holds off until the core has caught up.
        if ($urandom_range(59, 0) == 0) drain();
      end
    end

    drain();
    // An init takes a full sweep of the memories; wait that long again for
    // any stray beat.
    repeat (NPAGES + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS page_frame_allocator_refcount_core");
    end else begin
      $display("FAIL page_frame_allocator_refcount_core");
    end
    $finish;
  end

endmodule
